// ===== rtl/stq_pkg.sv =====
package stq_pkg;

    localparam int QueueDepth = 16;
    localparam int IdxBits = $clog2(QueueDepth);
    localparam int CntBits = $clog2(QueueDepth + 1);
    localparam int JobBits = 8;
    localparam int TimeBits = 48;
    localparam int PerBits = 32;
    localparam int MaxFires = 16;
    localparam int FireBits = $clog2(MaxFires + 1);

    typedef enum logic [1:0] {
        ACT_ADD_PER  = 2'd0,
        ACT_ADD_ONE  = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_TICK     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        K_FIRED    = 3'd0,
        K_ADDED    = 3'd1,
        K_FULL     = 3'd2,
        K_REMOVED  = 3'd3,
        K_NOTFOUND = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_REM_SCAN,
        S_DEL_SHIFT,
        S_TICK_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                load_item;
        logic                add_setup;
        logic                tick_setup;
        logic                scan_clear;
        logic                scan_step;
        logic                shift_up;
        logic                ins_write;
        logic                shift_down;
        logic                del_start;
        logic                head_capture;
        logic                requeue_setup;
        logic                set_result;
        kind_t               res_kind;
        logic                res_use_head;
    } dp_cmd_t;

    typedef struct packed {
        logic                full;
        logic                scan_end;
        logic                scan_hit;
        logic                shift_done;
        logic                head_due;
        logic                head_periodic;
        logic                fires_max;
        logic                next_due;
        action_t             action;
    } dp_stat_t;

endpackage

// ===== rtl/stq_datapath.sv =====
module stq_datapath
    import stq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [1:0]          action,
    input  logic [7:0]          job_id,
    input  logic [31:0]         interval_ms,
    output logic [2:0]          kind,
    output logic [7:0]          job_id_out
);

    logic [TimeBits-1:0] due_mem [QueueDepth];
    logic [PerBits-1:0]  per_mem [QueueDepth];
    logic [JobBits-1:0]  job_mem [QueueDepth];
    logic                prd_mem [QueueDepth];

    logic [CntBits-1:0]  count_reg, count_next;
    logic [TimeBits-1:0] now_reg, now_next;
    logic [CntBits-1:0]  ptr_reg, ptr_next;
    logic [CntBits-1:0]  pos_reg, pos_next;
    logic [FireBits-1:0] fires_reg, fires_next;

    action_t             act_reg;
    logic [JobBits-1:0]  job_reg;
    logic [PerBits-1:0]  ival_reg;

    logic [TimeBits-1:0] new_due_reg;
    logic [PerBits-1:0]  new_per_reg;
    logic [JobBits-1:0]  new_job_reg;
    logic                new_prd_reg;

    logic [TimeBits-1:0] h_due_reg;
    logic [PerBits-1:0]  h_per_reg;
    logic [JobBits-1:0]  h_job_reg;
    logic                h_prd_reg;

    logic [2:0]          kind_reg;
    logic [JobBits-1:0]  res_job_reg;

    logic [IdxBits-1:0]  ptr_idx;
    logic [IdxBits-1:0]  ptr_m1;
    logic [PerBits-1:0]  add_per;

    assign ptr_idx = ptr_reg[IdxBits-1:0];
    assign ptr_m1  = IdxBits'(ptr_reg - CntBits'(1));
    assign add_per = (ival_reg == '0 && act_reg == ACT_ADD_PER) ? PerBits'(1) : ival_reg;

    always_comb
    begin
        stat.full          = (count_reg == CntBits'(QueueDepth));
        stat.scan_end      = (ptr_reg >= count_reg);
        stat.scan_hit      = (act_reg == ACT_REMOVE) ? (job_mem[ptr_idx] == job_reg)
                                                     : (due_mem[ptr_idx] > new_due_reg);
        stat.shift_done    = (ptr_reg <= pos_reg);
        stat.head_due      = (count_reg != '0) && (due_mem[0] <= now_reg);
        stat.head_periodic = h_prd_reg;
        stat.fires_max     = (fires_reg == FireBits'(MaxFires));
        stat.next_due      = (ptr_reg + CntBits'(1) >= count_reg);
        stat.action        = act_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            now_reg   <= '0;
            ptr_reg   <= '0;
            pos_reg   <= '0;
            fires_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            now_reg   <= now_next;
            ptr_reg   <= ptr_next;
            pos_reg   <= pos_next;
            fires_reg <= fires_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        now_next   = now_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        fires_next = fires_reg;
        if (cmd.tick_setup)
        begin
            now_next   = now_reg + TimeBits'(1);
            fires_next = '0;
        end
        if (cmd.scan_clear)
            ptr_next = '0;
        if (cmd.scan_step)
            ptr_next = ptr_reg + CntBits'(1);
        if (cmd.add_setup || cmd.requeue_setup)
            ptr_next = '0;
        if (cmd.shift_up)
        begin
            pos_next = ptr_reg;
            ptr_next = count_reg;
        end
        if (cmd.ins_write)
        begin
            if (ptr_reg > pos_reg)
                ptr_next = ptr_reg - CntBits'(1);
            else
                count_next = count_reg + CntBits'(1);
        end
        if (cmd.del_start)
            ptr_next = ptr_reg;
        if (cmd.shift_down)
        begin
            if (ptr_reg + CntBits'(1) < count_reg)
                ptr_next = ptr_reg + CntBits'(1);
            else
                count_next = count_reg - CntBits'(1);
        end
        if (cmd.head_capture)
        begin
            fires_next = fires_reg + FireBits'(1);
            ptr_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg  <= action_t'(action);
            job_reg  <= job_id[JobBits-1:0];
            ival_reg <= interval_ms;
        end
        if (cmd.add_setup)
        begin
            new_due_reg <= now_reg + TimeBits'(add_per);
            new_per_reg <= (act_reg == ACT_ADD_PER) ? add_per : '0;
            new_job_reg <= job_reg;
            new_prd_reg <= (act_reg == ACT_ADD_PER);
        end
        if (cmd.requeue_setup)
        begin
            new_due_reg <= h_due_reg + TimeBits'(h_per_reg);
            new_per_reg <= h_per_reg;
            new_job_reg <= h_job_reg;
            new_prd_reg <= 1'b1;
        end
        if (cmd.head_capture)
        begin
            h_due_reg <= due_mem[0];
            h_per_reg <= per_mem[0];
            h_job_reg <= job_mem[0];
            h_prd_reg <= prd_mem[0];
        end
        if (cmd.ins_write)
        begin
            if (ptr_reg > pos_reg)
            begin
                due_mem[ptr_idx] <= due_mem[ptr_m1];
                per_mem[ptr_idx] <= per_mem[ptr_m1];
                job_mem[ptr_idx] <= job_mem[ptr_m1];
                prd_mem[ptr_idx] <= prd_mem[ptr_m1];
            end
            else
            begin
                due_mem[ptr_idx] <= new_due_reg;
                per_mem[ptr_idx] <= new_per_reg;
                job_mem[ptr_idx] <= new_job_reg;
                prd_mem[ptr_idx] <= new_prd_reg;
            end
        end
        if (cmd.shift_down && (ptr_reg + CntBits'(1) < count_reg))
        begin
            due_mem[ptr_idx] <= due_mem[IdxBits'(ptr_reg + CntBits'(1))];
            per_mem[ptr_idx] <= per_mem[IdxBits'(ptr_reg + CntBits'(1))];
            job_mem[ptr_idx] <= job_mem[IdxBits'(ptr_reg + CntBits'(1))];
            prd_mem[ptr_idx] <= prd_mem[IdxBits'(ptr_reg + CntBits'(1))];
        end
        if (cmd.set_result)
        begin
            kind_reg    <= cmd.res_kind;
            res_job_reg <= cmd.res_use_head ? h_job_reg : job_reg;
        end
    end

    assign kind       = kind_reg;
    assign job_id_out = 8'(res_job_reg);

endmodule

// ===== rtl/stq_ctrl.sv =====
module stq_ctrl
    import stq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     last,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;
    logic   fired_reg, fired_next;
    logic   last_reg, last_next;
    logic   more_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fired_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fired_reg <= fired_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign last      = last_reg;
    assign more_fire = stat.head_due && !stat.fires_max;

    always_comb
    begin
        state_next = state_reg;
        fired_next = fired_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.res_kind = K_FIRED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.action) inside
                    ACT_ADD_PER, ACT_ADD_ONE:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_result = 1'b1;
                            cmd.res_kind   = K_FULL;
                            last_next      = 1'b1;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cmd.add_setup = 1'b1;
                            state_next    = S_INS_SCAN;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_REM_SCAN;
                    end
                    default:
                    begin
                        cmd.tick_setup = 1'b1;
                        state_next     = S_TICK_CHECK;
                    end
                endcase
            end
            S_INS_SCAN:
            begin
                if (stat.scan_end || stat.scan_hit)
                begin
                    cmd.shift_up = 1'b1;
                    state_next   = S_INS_SHIFT;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_INS_SHIFT:
            begin
                cmd.ins_write = 1'b1;
                if (stat.shift_done)
                begin
                    if (stat.action == ACT_TICK)
                        state_next = S_TICK_CHECK;
                    else
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_kind   = K_ADDED;
                        last_next      = 1'b1;
                        state_next     = S_OUT;
                    end
                end
            end
            S_REM_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_kind   = K_NOTFOUND;
                    last_next      = 1'b1;
                    state_next     = S_OUT;
                end
                else if (stat.scan_hit)
                begin
                    cmd.del_start = 1'b1;
                    state_next    = S_DEL_SHIFT;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_DEL_SHIFT:
            begin
                cmd.shift_down = 1'b1;
                if (stat.next_due)
                begin
                    if (stat.action == ACT_REMOVE)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_kind   = K_REMOVED;
                        last_next      = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (stat.head_periodic)
                    begin
                        cmd.requeue_setup = 1'b1;
                        state_next        = S_INS_SCAN;
                    end
                    else
                        state_next = S_TICK_CHECK;
                end
            end
            S_TICK_CHECK:
            begin
                // fired word goes out before the next head is captured
                if (fired_reg)
                begin
                    cmd.set_result   = 1'b1;
                    cmd.res_kind     = K_FIRED;
                    cmd.res_use_head = 1'b1;
                    last_next        = !more_fire;
                    fired_next       = 1'b0;
                    state_next       = S_OUT;
                end
                else if (more_fire)
                begin
                    cmd.head_capture = 1'b1;
                    fired_next       = 1'b1;
                    state_next       = S_DEL_SHIFT;
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = last_reg ? S_IDLE : S_TICK_CHECK;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/sorted_timer_event_queue.sv =====
// channel | signals                                  | word
// input   | valid ready action job_id interval_ms    | one request
// output  | out_valid out_ready kind job_id_out last | one result
// Each accepted request yields result words: one for an add, an add to
// a full queue or a remove (found or not). A tick is decoded, then each
// fired entry is deleted (one-shot) or deleted and re-inserted (periodic),
// giving one word each; a tick with nothing due gives no result word.
// Reset clears count and time; entry storage is undefined until written.
// A stalled output word holds the controller; input is ready only in idle.
module sorted_timer_event_queue
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  action,
    input  logic [7:0]  job_id,
    input  logic [31:0] interval_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  job_id_out,
    output logic        last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .in_ready  (ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat)
    );

    stq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .job_id      (job_id),
        .interval_ms (interval_ms),
        .kind        (kind),
        .job_id_out  (job_id_out)
    );

endmodule

// ===== test/sorted_timer_event_queue_checker.sv =====
module sorted_timer_event_queue_checker
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic        ready,
    input  logic [1:0]  action,
    input  logic [7:0]  job_id,
    input  logic [31:0] interval_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  job_id_out,
    input  logic        last,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] job;
        logic       last;
    } timer_result_t;

    typedef struct packed {
        logic [TimeBits-1:0] due;
        logic [PerBits-1:0]  per;
        logic [JobBits-1:0]  job;
        logic                periodic;
    } timer_entry_t;

    timer_entry_t    sched_q[$];
    logic [TimeBits-1:0] now_ms;
    timer_result_t   result_q[$];

    function automatic void sched_insert(timer_entry_t e);
        int pos;
        pos = 0;
        while (pos < sched_q.size() && sched_q[pos].due <= e.due)
            pos++;
        sched_q.insert(pos, e);
    endfunction

    task automatic predict_word(action_t act, logic [7:0] job, logic [31:0] ivl);
        timer_entry_t e;
        logic [31:0] per;
        int n;
        bit found;
        case (act) inside
            ACT_ADD_PER, ACT_ADD_ONE:
            begin
                per = ivl;
                if (act == ACT_ADD_PER && per == '0)
                    per = 32'd1;
                if (sched_q.size() >= QueueDepth)
                    result_q.push_back('{K_FULL, job, 1'b1});
                else
                begin
                    e.due = now_ms + TimeBits'(per);
                    e.per = (act == ACT_ADD_PER) ? per : '0;
                    e.job = job;
                    e.periodic = (act == ACT_ADD_PER);
                    sched_insert(e);
                    result_q.push_back('{K_ADDED, job, 1'b1});
                end
            end
            ACT_REMOVE:
            begin
                found = 0;
                for (int i = 0; i < sched_q.size() && !found; i++)
                begin
                    if (sched_q[i].job == job)
                    begin
                        sched_q.delete(i);
                        found = 1;
                    end
                end
                result_q.push_back('{found ? K_REMOVED : K_NOTFOUND, job, 1'b1});
            end
            default:
            begin
                now_ms = now_ms + TimeBits'(1);
                n = 0;
                while (n < MaxFires && sched_q.size() > 0 && sched_q[0].due <= now_ms)
                begin
                    e = sched_q[0];
                    sched_q.delete(0);
                    if (e.periodic)
                    begin
                        e.due = e.due + TimeBits'(e.per);
                        sched_insert(e);
                    end
                    result_q.push_back('{K_FIRED, e.job, 1'b0});
                    n++;
                end
                if (n > 0)
                    result_q[$].last = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t exp_r;
        if (!rst_n)
        begin
            sched_q.delete();
            result_q.delete();
            now_ms = '0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result kind=%0d job=%0d", kind, job_id_out);
                    fail_count++;
                end
                else
                begin
                    exp_r = result_q[0];
                    result_q.delete(0);
                    if (kind !== exp_r.kind)
                    begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                        fail_count++;
                    end
                    if (job_id_out !== exp_r.job)
                    begin
                        $error("job_id_out: expected %0d, got %0d", exp_r.job, job_id_out);
                        fail_count++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_r.last, last);
                        fail_count++;
                    end
                end
            end
            if (valid && ready)
                predict_word(action_t'(action), job_id, interval_ms);
        end
        pending_results = result_q.size();
    end

endmodule

// ===== test/sorted_timer_event_queue_test.sv =====
module sorted_timer_event_queue_test
    import stq_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  job_id;
    logic [31:0] interval_ms;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  job_id_out;
    logic        last;
    int          fail_count;
    int          pending_results;
    int          quiet_cycles;
    bit          calm;

    localparam int WatchdogLimit = 20000;

    sorted_timer_event_queue i_dut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready), .action(action),
        .job_id(job_id), .interval_ms(interval_ms), .out_valid(out_valid),
        .out_ready(out_ready), .kind(kind), .job_id_out(job_id_out), .last(last)
    );

    sorted_timer_event_queue_checker i_checker (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready), .action(action),
        .job_id(job_id), .interval_ms(interval_ms), .out_valid(out_valid),
        .out_ready(out_ready), .kind(kind), .job_id_out(job_id_out), .last(last),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
            out_ready <= calm || ($urandom_range(99) >= 25);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (valid && ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(action_t act, logic [7:0] job, logic [31:0] ivl);
        while (!calm && $urandom_range(99) < 25)
        begin
            valid <= 0;
            @(negedge clk);
        end
        valid <= 1;
        action <= act;
        job_id <= job;
        interval_ms <= ivl;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            send_word(ACT_TICK, 8'($urandom), $urandom);
        else if (r < 50)
            send_word(ACT_ADD_PER, 8'($urandom_range(15)), $urandom_range(12));
        else if (r < 65)
            send_word(ACT_ADD_ONE, 8'($urandom_range(15)), $urandom_range(12));
        else if (r < 85)
            send_word(ACT_REMOVE, 8'($urandom_range(15)), $urandom);
        else
            send_word(action_t'($urandom_range(2)), 8'($urandom), $urandom);
    endtask

    initial
    begin
        rst_n = 0;
        valid = 0;
        action = ACT_TICK;
        job_id = 0;
        interval_ms = 0;
        calm = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_word(ACT_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_word(ACT_REMOVE, 8'd9, 32'd0);
        send_word(ACT_ADD_PER, 8'd0, 32'd0);
        send_word(ACT_ADD_ONE, 8'hFF, 32'd0);
        send_word(ACT_ADD_ONE, 8'hAA, 32'hFFFF_FFFF);
        send_word(ACT_ADD_PER, 8'h55, 32'hFFFF_FFFF);
        send_word(ACT_ADD_PER, 8'h01, 32'd2);
        send_word(ACT_ADD_PER, 8'h01, 32'd2);
        send_word(ACT_TICK, 8'd0, 32'd0);
        send_word(ACT_TICK, 8'd0, 32'd0);
        send_word(ACT_REMOVE, 8'h00, 32'hFFFF_FFFF);
        send_word(ACT_REMOVE, 8'h01, 32'd0);
        for (int i = 0; i < 11; i++)
            send_word(ACT_ADD_PER, 8'(16 + i), 32'd0);
        send_word(ACT_ADD_ONE, 8'd99, 32'd1);
        send_word(ACT_TICK, 8'd0, 32'd0);
        valid <= 0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        for (int i = 0; i < 16; i++)
            send_word(ACT_REMOVE, 8'(16 + i), 32'd0);

        for (int n = 0; n < 400; n++)
        begin
            calm = (n >= 150 && n < 220);
            if (n == 300)
            begin
                valid <= 0;
                while (pending_results != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            random_word();
        end
        calm = 0;
        valid <= 0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/stq_pkg.sv
rtl/stq_datapath.sv
rtl/stq_ctrl.sv
rtl/sorted_timer_event_queue.sv
test/sorted_timer_event_queue_checker.sv
test/sorted_timer_event_queue_test.sv
